[rtl/fhcp_pkg.sv]
// Package for the FITS header card parser: result kinds, status codes, card result type.
// No dependencies.
package fhcp_pkg;

  localparam int ValueBitsDefault = 32;
  localparam int CardLen = 80;
  localparam int CardsPerBlock = 36;

  localparam logic [2:0] KIND_END    = 3'd0;
  localparam logic [2:0] KIND_SIMPLE = 3'd1;
  localparam logic [2:0] KIND_BITPIX = 3'd2;
  localparam logic [2:0] KIND_NAXIS  = 3'd3;
  localparam logic [2:0] KIND_AXIS   = 3'd4;
  localparam logic [2:0] KIND_SKIP   = 3'd5;
  localparam logic [2:0] KIND_FAIL   = 3'd6;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_BADVAL  = 3'd2;
  localparam logic [2:0] ST_NOTSIMP = 3'd3;
  localparam logic [2:0] ST_UNSUP   = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_WS    = 3'd1;
  localparam logic [2:0] PH_SIGN  = 3'd2;
  localparam logic [2:0] PH_DIGIT = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  typedef struct packed {
    logic [2:0]  card_kind;
    logic        done_res;
    logic [2:0]  status;
    logic [2:0]  pixel_type;
    logic [1:0]  num_axes;
    logic [30:0] width;
    logic [30:0] height;
    logic [30:0] depth;
    logic [11:0] pad_bytes;
  } result_t;

endpackage

[rtl/fhcp_front.sv]
// Front end: groups bytes into cards, captures keyword, '=' and 'T', and scans the integer.
// Emits one card record per finished card or truncation. Depends on fhcp_pkg.
module fhcp_front #(
  parameter int VALUE_BITS = fhcp_pkg::ValueBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            header_byte,
  input  logic                  restart,
  input  logic                  stream_end,
  output logic                  card_valid,
  output logic                  card_trunc,
  output logic                  card_se,
  output logic                  card_first,
  output logic [55:0]           card_kw,
  output logic                  card_eq,
  output logic                  card_flag,
  output logic [2:0]            card_phase,
  output logic                  card_neg,
  output logic [VALUE_BITS-1:0] card_accum
);

  localparam logic [VALUE_BITS-1:0] Cap = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [6:0]            card_column;
  logic [55:0]           keyword_bytes;
  logic                  equals_seen, flag_is_true, number_negative;
  logic [2:0]            number_phase;
  logic [VALUE_BITS-1:0] number_accum;
  logic                  first_pending;

  logic [6:0]            c;
  logic [55:0]           kw_next;
  logic                  eq_next, flag_next, neg_next;
  logic [2:0]            ph_next;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  digit, ws;
  logic [3:0]            d;
  logic [VALUE_BITS+3:0] prod;
  logic                  card_done;

  assign digit = header_byte >= 8'h30 && header_byte <= 8'h39;
  assign ws    = header_byte == 8'h20 || (header_byte >= 8'd9 && header_byte <= 8'd13);
  assign d     = header_byte[3:0];
  assign prod  = {4'd0, number_accum} * (VALUE_BITS+4)'(10) + {{VALUE_BITS{1'b0}}, d};
  assign card_done = c == 7'(fhcp_pkg::CardLen - 1) || stream_end;

  always_comb begin
    c = restart ? 7'd0 : card_column;
    kw_next   = restart ? '0 : keyword_bytes;
    eq_next   = restart ? 1'b0 : equals_seen;
    flag_next = restart ? 1'b0 : flag_is_true;
    neg_next  = restart ? 1'b0 : number_negative;
    ph_next   = restart ? fhcp_pkg::PH_LEAD : number_phase;
    acc_next  = restart ? '0 : number_accum;
    if (c < 7'd7) kw_next[8*(6-c[2:0]) +: 8] = header_byte;
    if ((c == 7'd7 || c == 7'd8) && header_byte == 8'h3d) eq_next = 1'b1;
    if (c == 7'd29) flag_next = header_byte == 8'h54;
    if (c >= 7'd9 && c <= 7'd29) begin
      if (ph_next == fhcp_pkg::PH_LEAD && !(header_byte == 8'h20 || header_byte == 8'h00))
        ph_next = fhcp_pkg::PH_WS;
      if (ph_next == fhcp_pkg::PH_WS) begin
        if (!ws) begin
          if (header_byte == 8'h2b) ph_next = fhcp_pkg::PH_SIGN;
          else if (header_byte == 8'h2d) begin
            neg_next = 1'b1;
            ph_next  = fhcp_pkg::PH_SIGN;
          end else if (digit) ph_next = fhcp_pkg::PH_DIGIT;
          else ph_next = fhcp_pkg::PH_STOP;
        end
      end else if (ph_next == fhcp_pkg::PH_SIGN || ph_next == fhcp_pkg::PH_DIGIT) begin
        ph_next = digit ? fhcp_pkg::PH_DIGIT : fhcp_pkg::PH_STOP;
      end
      // accumulate, saturating at 2^(VALUE_BITS-1)
      if (digit && ph_next == fhcp_pkg::PH_DIGIT) begin
        if (prod > {4'd0, Cap}) acc_next = Cap;
        else acc_next = prod[VALUE_BITS-1:0];
      end
    end
  end

  // Saturation always works from the registered accum; with restart the column is zero,
  // outside the value columns, so no digit is accumulated.

  always_ff @(posedge clk) begin
    if (rst) begin
      card_column <= '0;
      keyword_bytes <= '0;
      equals_seen <= 1'b0;
      flag_is_true <= 1'b0;
      number_negative <= 1'b0;
      number_phase <= fhcp_pkg::PH_LEAD;
      number_accum <= '0;
      card_valid <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      card_valid <= 1'b0;
      if (in_valid) begin
        // hold a restart until the record that follows it reaches the back end
        card_first <= restart || first_pending;
        first_pending <= (restart || first_pending) && !card_done;
        card_kw <= kw_next;
        card_eq <= eq_next;
        card_flag <= flag_next;
        card_phase <= ph_next;
        card_neg <= neg_next;
        card_accum <= acc_next;
        card_se <= stream_end;
        if (c == 7'(fhcp_pkg::CardLen - 1)) begin
          card_column <= '0;
          keyword_bytes <= '0;
          equals_seen <= 1'b0;
          flag_is_true <= 1'b0;
          number_negative <= 1'b0;
          number_phase <= fhcp_pkg::PH_LEAD;
          number_accum <= '0;
          card_valid <= 1'b1;
          card_trunc <= 1'b0;
        end else begin
          card_column <= c + 7'd1;
          keyword_bytes <= kw_next;
          equals_seen <= eq_next;
          flag_is_true <= flag_next;
          number_negative <= neg_next;
          number_phase <= ph_next;
          number_accum <= acc_next;
          card_valid <= stream_end;
          card_trunc <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/fhcp_back.sv]
// Back end: evaluates card records against header state and builds result items.
// Depends on fhcp_pkg.
module fhcp_back #(
  parameter int VALUE_BITS = fhcp_pkg::ValueBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  card_valid,
  input  logic                  card_trunc,
  input  logic                  card_se,
  input  logic                  card_first,
  input  logic [55:0]           card_kw,
  input  logic                  card_eq,
  input  logic                  card_flag,
  input  logic [2:0]            card_phase,
  input  logic                  card_neg,
  input  logic [VALUE_BITS-1:0] card_accum,
  output logic                  res_valid,
  output fhcp_pkg::result_t     res
);

  localparam logic [VALUE_BITS-1:0] Cap = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] LenMax =
      (VALUE_BITS > 31) ? VALUE_BITS'(64'h7fff_ffff) : {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef logic signed [VALUE_BITS-1:0] sval_t;

  logic [5:0] cards_in_block;
  logic       simple_seen, finished;
  sval_t      bits_per_pixel;
  logic [1:0] axes_count;
  sval_t      axis_lengths [3];

  logic [5:0] cib;
  logic       ss_cur, fin_cur;
  sval_t      bpp_cur;
  logic [1:0] ax_cur;
  sval_t      len_cur [3];
  sval_t      v;
  logic       has_val;
  logic [2:0] kind, st, ptype;
  logic [5:0] cib_next;
  logic [1:0] n;
  sval_t      h, dd;
  fhcp_pkg::result_t r;
  logic       ss_n;
  sval_t      bpp_n;
  logic [1:0] ax_n;
  sval_t      len_n [3];
  logic [5:0] rem;

  function automatic logic [30:0] clamp_len(input sval_t x);
    if (x < 0) return '0;
    if ($unsigned(x) > LenMax) return 31'h7fff_ffff;
    return 31'($unsigned(x));
  endfunction

  always_comb begin
    cib = card_first ? 6'd0 : cards_in_block;
    ss_cur  = card_first ? 1'b0 : simple_seen;
    fin_cur = card_first ? 1'b0 : finished;
    bpp_cur = card_first ? '0 : bits_per_pixel;
    ax_cur  = card_first ? 2'd0 : axes_count;
    for (int i = 0; i < 3; i++) len_cur[i] = card_first ? '0 : axis_lengths[i];
    has_val = card_eq && card_phase != fhcp_pkg::PH_LEAD;
    // the magnitude never exceeds 2^(VALUE_BITS-1), so a plain negate saturates
    if (card_neg) v = -$signed(card_accum);
    else v = (card_accum >= Cap) ? $signed(Cap - 1'b1) : $signed(card_accum);
    cib_next = (cib == 6'(fhcp_pkg::CardsPerBlock - 1)) ? 6'd0 : cib + 6'd1;
    ss_n = ss_cur; bpp_n = bpp_cur; ax_n = ax_cur;
    for (int i = 0; i < 3; i++) len_n[i] = len_cur[i];
    n = 2'(card_kw[15:8] - 8'h31);
    kind = fhcp_pkg::KIND_FAIL;
    st = fhcp_pkg::ST_RUN;
    if (card_kw[55:24] == "END ") kind = fhcp_pkg::KIND_END;
    else if (card_kw == "SIMPLE ") begin
      if (!card_flag) begin ss_n = 1'b0; st = fhcp_pkg::ST_NOTSIMP; end
      else begin ss_n = 1'b1; kind = fhcp_pkg::KIND_SIMPLE; end
    end else if (card_kw == "BITPIX ") begin
      if (!ss_cur) st = fhcp_pkg::ST_INVALID;
      else if (!has_val) st = fhcp_pkg::ST_BADVAL;
      else begin
        bpp_n = v;
        if (v == 0) st = fhcp_pkg::ST_UNSUP;
        else kind = fhcp_pkg::KIND_BITPIX;
      end
    end else if (card_kw[55:8] == "NAXIS ") begin
      if (!has_val) st = fhcp_pkg::ST_BADVAL;
      else if (v < 1 || v > 3) st = fhcp_pkg::ST_UNSUP;
      else begin ax_n = 2'(v); kind = fhcp_pkg::KIND_NAXIS; end
    end else if (card_kw[55:16] == "NAXIS" && card_kw[7:0] == 8'h20 &&
                 card_kw[15:8] >= 8'h31 && card_kw[15:8] <= 8'h33) begin
      if (ax_cur == 2'd0 || ax_cur <= n) st = fhcp_pkg::ST_INVALID;
      else if (!has_val) st = fhcp_pkg::ST_BADVAL;
      else begin len_n[n] = v; kind = fhcp_pkg::KIND_AXIS; end
    end else kind = fhcp_pkg::KIND_SKIP;
    if (st == fhcp_pkg::ST_RUN && card_se) st = fhcp_pkg::ST_BADVAL;
    r = '0;
    r.card_kind = kind;
    rem = (cib_next == 6'd0) ? 6'd0 : 6'(fhcp_pkg::CardsPerBlock) - cib_next;
    ptype = 3'd0;
    if (st == fhcp_pkg::ST_RUN && kind == fhcp_pkg::KIND_END) begin
      r.pad_bytes = 12'(rem) * 12'(fhcp_pkg::CardLen);
      h = len_cur[1]; dd = len_cur[2];
      if (ax_cur == 2'd1) begin h = sval_t'(1); dd = sval_t'(1); end
      else if (ax_cur == 2'd2) dd = sval_t'(1);
      st = fhcp_pkg::ST_OK;
      if (bpp_cur == 8) ptype = 3'd0;
      else if (bpp_cur == 16) ptype = 3'd1;
      else if (bpp_cur == 32) ptype = 3'd2;
      else if (bpp_cur == -32) ptype = 3'd3;
      else if (bpp_cur == -64) ptype = 3'd4;
      else st = fhcp_pkg::ST_INVALID;
      if (ax_cur == 2'd0) st = fhcp_pkg::ST_INVALID;
      if (len_cur[0] <= 0 || h <= 0 || dd <= 0) st = fhcp_pkg::ST_INVALID;
      if (st == fhcp_pkg::ST_OK) begin
        r.pixel_type = ptype;
        r.width  = clamp_len(len_cur[0]);
        r.height = clamp_len(h);
        r.depth  = clamp_len(dd);
      end
    end else begin
      h = '0; dd = '0;
    end
    if (card_trunc) begin
      r = '0;
      r.card_kind = fhcp_pkg::KIND_FAIL;
      st = fhcp_pkg::ST_BADVAL;
    end
    if (st != fhcp_pkg::ST_RUN) begin
      r.done_res = 1'b1;
      r.status = st;
      r.num_axes = card_trunc ? 2'd0 : ax_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cards_in_block <= '0;
      simple_seen <= 1'b0;
      finished <= 1'b0;
      bits_per_pixel <= '0;
      axes_count <= '0;
      for (int i = 0; i < 3; i++) axis_lengths[i] <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (card_valid && !fin_cur) begin
        res_valid <= 1'b1;
        res <= r;
        finished <= r.done_res;
        if (!card_trunc) begin
          cards_in_block <= cib_next;
          simple_seen <= ss_n;
          bits_per_pixel <= bpp_n;
          axes_count <= ax_n;
          for (int i = 0; i < 3; i++) axis_lengths[i] <= len_n[i];
        end
      end else if (card_valid && card_first) begin
        finished <= 1'b0;
      end
    end
  end

endmodule

[rtl/fhcp_queue.sv]
// Result queue: small FIFO between back end and the result port, with credit-based full.
// Depends on fhcp_pkg.
module fhcp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  fhcp_pkg::result_t wdata,
  input  logic              rd,
  output fhcp_pkg::result_t rdata,
  output logic              empty,
  output logic              almost_full
);

  localparam int AW = $clog2(DEPTH);

  fhcp_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign empty = count == '0;
  assign rdata = mem[rp];
  // two items may still be in flight in the front and back stages
  assign almost_full = count >= (AW+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd && !empty) rp <= rp + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd && !empty);
    end
  end

endmodule

[rtl/fits_header_card_parser_core.sv]
// FITS header card parser top level: front end, back end and result queue.
// Depends on fhcp_pkg, fhcp_front, fhcp_back, fhcp_queue.
// Takes one header byte per cycle while full is low; a card result reaches the result ports
// through the front register at the edge that accepts the card's last byte, then the back
// register, then the queue write. full rises when the four-entry result queue holds
// two items, so it can still absorb the two items that may be in flight.
module fits_header_card_parser_core #(
  parameter int VALUE_BITS = fhcp_pkg::ValueBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  header_byte,
  input  logic        restart,
  input  logic        stream_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  card_kind,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [2:0]  pixel_type,
  output logic [1:0]  num_axes,
  output logic [30:0] width,
  output logic [30:0] height,
  output logic [30:0] depth,
  output logic [11:0] pad_bytes
);

  logic cv, ct, cs, cf, ce, cfl, cn;
  logic [55:0] ck;
  logic [2:0] cp;
  logic [VALUE_BITS-1:0] ca;
  logic rv;
  fhcp_pkg::result_t r, q;

  fhcp_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid(push && !full), .header_byte, .restart, .stream_end,
    .card_valid(cv), .card_trunc(ct), .card_se(cs), .card_first(cf), .card_kw(ck),
    .card_eq(ce), .card_flag(cfl), .card_phase(cp), .card_neg(cn), .card_accum(ca));

  fhcp_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .card_valid(cv), .card_trunc(ct), .card_se(cs), .card_first(cf),
    .card_kw(ck), .card_eq(ce), .card_flag(cfl), .card_phase(cp), .card_neg(cn),
    .card_accum(ca), .res_valid(rv), .res(r));

  fhcp_queue #(.DEPTH(4)) u_queue (
    .clk, .rst, .wr(rv), .wdata(r), .rd(pop), .rdata(q), .empty, .almost_full(full));

  assign card_kind  = q.card_kind;
  assign done_res   = q.done_res;
  assign status     = q.status;
  assign pixel_type = q.pixel_type;
  assign num_axes   = q.num_axes;
  assign width      = q.width;
  assign height     = q.height;
  assign depth      = q.depth;
  assign pad_bytes  = q.pad_bytes;

endmodule

[rtl/fhcp_checker.sv]
// Port-level checks for the FITS header card parser, bound to the top level.
// Depends on fhcp_pkg and fits_header_card_parser_core.
module fhcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        done_res,
  input logic [2:0]  status,
  input logic [2:0]  card_kind,
  input logic [11:0] pad_bytes
);

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (done_res == (status != fhcp_pkg::ST_RUN))) else $error("done/status mismatch");
  // pad comes only with an END card that closes a header that was not cut short
  a_pad_end: assert property (@(posedge clk) disable iff (rst)
    !empty && pad_bytes != 12'd0 |-> card_kind == fhcp_pkg::KIND_END &&
      (status == fhcp_pkg::ST_OK || status == fhcp_pkg::ST_INVALID))
    else $error("pad on non-end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(card_kind)) else $error("result dropped");

endmodule

bind fits_header_card_parser_core fhcp_checker u_chk (
  .clk, .rst, .empty, .pop, .done_res, .status, .card_kind, .pad_bytes);

[tb/sv/tb_fits_header_card_parser_core.sv]
// Self-checking testbench for fits_header_card_parser_core: directed cards, then random cards.
// Depends on fhcp_pkg and the RTL of the card parser; expected results come from a local model.
`timescale 1ns / 100ps
module tb_fits_header_card_parser_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  header_byte = 8'd0;
  logic        restart = 1'b0;
  logic        stream_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  card_kind;
  logic        done_res;
  logic [2:0]  status;
  logic [2:0]  pixel_type;
  logic [1:0]  num_axes;
  logic [30:0] width;
  logic [30:0] height;
  logic [30:0] depth;
  logic [11:0] pad_bytes;

  fits_header_card_parser_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .header_byte(header_byte),
    .restart(restart), .stream_end(stream_end), .empty(empty), .pop(pop),
    .card_kind(card_kind), .done_res(done_res), .status(status), .pixel_type(pixel_type),
    .num_axes(num_axes), .width(width), .height(height), .depth(depth),
    .pad_bytes(pad_bytes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam int WatchdogLimit = 20000;
  localparam int PhaseBytes = 60;
  localparam int CardLen = fhcp_pkg::CardLen;
  localparam int CardsPerBlock = fhcp_pkg::CardsPerBlock;
  localparam logic [63:0] ValueCap = 64'd1 << 31;

  fhcp_pkg::result_t card_results[$];
  int      errors = 0;
  int      results_seen = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  bit      hold_start = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  // model state of the parser
  logic [6:0]  col_q;
  int          cards_q;
  logic [7:0]  kw_q [7];
  bit          eq_q, tflag_q, neg_q, simple_q, finished_q;
  logic [2:0]  phase_q;
  logic [63:0] accum_q;
  longint      bitpix_q;
  int          axes_q;
  longint      axis_len_q [3];

  function automatic void clear_card_state();
    for (int i = 0; i < 7; i++) kw_q[i] = 8'd0;
    eq_q = 0; tflag_q = 0; neg_q = 0; phase_q = fhcp_pkg::PH_LEAD; accum_q = 64'd0;
  endfunction

  function automatic void clear_header_state();
    clear_card_state();
    col_q = 0; cards_q = 0; simple_q = 0; bitpix_q = 0; axes_q = 0;
    for (int i = 0; i < 3; i++) axis_len_q[i] = 0;
    finished_q = 0;
  endfunction

  function automatic bit keyword_is(string s);
    for (int i = 0; i < s.len(); i++) if (kw_q[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void add_digit(logic [63:0] d);
    if (accum_q > (ValueCap - d) / 10) accum_q = ValueCap;
    else accum_q = accum_q * 10 + d;
  endfunction

  function automatic void feed_value(logic [7:0] b);
    bit is_digit;
    is_digit = b >= "0" && b <= "9";
    if (phase_q == fhcp_pkg::PH_LEAD) begin
      if (b == " " || b == 8'd0) return;
      phase_q = fhcp_pkg::PH_WS;
    end
    if (phase_q == fhcp_pkg::PH_WS) begin
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
      if (b == "+") phase_q = fhcp_pkg::PH_SIGN;
      else if (b == "-") begin
        neg_q = 1; phase_q = fhcp_pkg::PH_SIGN;
      end else if (is_digit) begin
        add_digit(64'(b - "0")); phase_q = fhcp_pkg::PH_DIGIT;
      end else phase_q = fhcp_pkg::PH_STOP;
    end else if (phase_q == fhcp_pkg::PH_SIGN || phase_q == fhcp_pkg::PH_DIGIT) begin
      if (is_digit) begin
        add_digit(64'(b - "0")); phase_q = fhcp_pkg::PH_DIGIT;
      end else phase_q = fhcp_pkg::PH_STOP;
    end
  endfunction

  function automatic bit card_number(output longint v);
    v = 0;
    if (!eq_q || phase_q == fhcp_pkg::PH_LEAD) return 0;
    if (neg_q) v = -longint'(accum_q);
    else v = accum_q >= ValueCap ? longint'(ValueCap - 1) : longint'(accum_q);
    return 1;
  endfunction

  function automatic logic [30:0] clamp_len(longint v);
    if (v < 0) return 31'd0;
    return v > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  // judge a finished card: kind and status out (run = keep going)
  function automatic void judge_card(output logic [2:0] kind, output logic [2:0] st);
    longint v;
    int n;
    kind = fhcp_pkg::KIND_FAIL; st = fhcp_pkg::ST_RUN;
    if (keyword_is("END ")) kind = fhcp_pkg::KIND_END;
    else if (keyword_is("SIMPLE ")) begin
      simple_q = tflag_q;
      if (!tflag_q) st = fhcp_pkg::ST_NOTSIMP;
      else kind = fhcp_pkg::KIND_SIMPLE;
    end else if (keyword_is("BITPIX ")) begin
      if (!simple_q) st = fhcp_pkg::ST_INVALID;
      else if (!card_number(v)) st = fhcp_pkg::ST_BADVAL;
      else begin
        bitpix_q = v;
        if (v == 0) st = fhcp_pkg::ST_UNSUP;
        else kind = fhcp_pkg::KIND_BITPIX;
      end
    end else if (keyword_is("NAXIS ")) begin
      if (!card_number(v)) st = fhcp_pkg::ST_BADVAL;
      else if (v < 1 || v > 3) st = fhcp_pkg::ST_UNSUP;
      else begin
        axes_q = int'(v); kind = fhcp_pkg::KIND_NAXIS;
      end
    end else if (keyword_is("NAXIS") && kw_q[6] == " " && kw_q[5] >= "1" && kw_q[5] <= "3")
    begin
      n = kw_q[5] - "1";
      if (axes_q == 0 || axes_q <= n) st = fhcp_pkg::ST_INVALID;
      else if (!card_number(v)) st = fhcp_pkg::ST_BADVAL;
      else begin
        axis_len_q[n] = v; kind = fhcp_pkg::KIND_AXIS;
      end
    end else kind = fhcp_pkg::KIND_SKIP;
  endfunction

  // advance the model by one accepted byte; returns 1 with the result if one is due
  function automatic bit parse_byte(logic [7:0] b, bit rs, bit se,
                                    output fhcp_pkg::result_t r);
    logic [2:0] kind, st;
    longint h, d;
    r = '0;
    if (rs) clear_header_state();
    if (finished_q) return 0;
    if (col_q < 7) kw_q[col_q] = b;
    if ((col_q == 7 || col_q == 8) && b == "=") eq_q = 1;
    if (col_q == 29) tflag_q = b == "T";
    if (col_q >= 9 && col_q <= 29) feed_value(b);
    if (col_q + 1 < CardLen) begin
      col_q++;
      if (!se) return 0;
      finished_q = 1;
      r.card_kind = fhcp_pkg::KIND_FAIL; r.done_res = 1; r.status = fhcp_pkg::ST_BADVAL;
      return 1;
    end
    col_q = 0;
    cards_q = (cards_q + 1) % CardsPerBlock;
    judge_card(kind, st);
    clear_card_state();
    r.card_kind = kind;
    if (st == fhcp_pkg::ST_RUN && se) st = fhcp_pkg::ST_BADVAL;
    if (st == fhcp_pkg::ST_RUN && kind == fhcp_pkg::KIND_END) begin
      r.pad_bytes = 12'(((CardsPerBlock - cards_q) % CardsPerBlock) * CardLen);
      h = axis_len_q[1]; d = axis_len_q[2];
      if (axes_q == 1) begin
        h = 1; d = 1;
      end else if (axes_q == 2) d = 1;
      st = fhcp_pkg::ST_OK;
      case (bitpix_q)
        8: r.pixel_type = 3'd0;
        16: r.pixel_type = 3'd1;
        32: r.pixel_type = 3'd2;
        -32: r.pixel_type = 3'd3;
        -64: r.pixel_type = 3'd4;
        default: st = fhcp_pkg::ST_INVALID;
      endcase
      if (axes_q == 0 || axis_len_q[0] <= 0 || h <= 0 || d <= 0) st = fhcp_pkg::ST_INVALID;
      if (st == fhcp_pkg::ST_OK) begin
        r.width = clamp_len(axis_len_q[0]); r.height = clamp_len(h); r.depth = clamp_len(d);
      end else begin
        // pad stays: it is given for any END that is not cut short
        r.pixel_type = 3'd0;
      end
    end
    if (st != fhcp_pkg::ST_RUN) begin
      finished_q = 1; r.done_res = 1; r.status = st; r.num_axes = axes_q[1:0];
    end
    return 1;
  endfunction

  // offer one byte, hold until accepted, then update the model
  task automatic send_byte(logic [7:0] b, bit rs, bit se, bit typed = 0,
                           fhcp_pkg::result_t typed_r = '0);
    fhcp_pkg::result_t r;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1; header_byte <= b; restart <= rs; stream_end <= se;
    @(posedge clk);
    while (full) @(posedge clk);
    if (parse_byte(b, rs, se, r)) begin
      if (typed) begin
        r.card_kind = typed_r.card_kind; r.done_res = typed_r.done_res;
        r.status = typed_r.status;
      end
      card_results.push_back(r);
    end
  endtask

  typedef logic [7:0] card_bytes_t [CardLen];

  function automatic card_bytes_t make_card(string kw, string val, bit eq);
    card_bytes_t c;
    for (int i = 0; i < CardLen; i++) c[i] = " ";
    for (int i = 0; i < kw.len() && i < 8; i++) c[i] = kw[i];
    if (eq) c[8] = "=";
    for (int i = 0; i < val.len() && i < 21; i++) c[30 - val.len() + i] = val[i];
    return c;
  endfunction

  task automatic send_card(card_bytes_t c, int len, bit rs, bit se, bit typed = 0,
                           fhcp_pkg::result_t typed_r = '0);
    for (int i = 0; i < len; i++)
      send_byte(c[i], rs && i == 0, se && i == len - 1, typed && i == len - 1, typed_r);
  endtask

  typedef struct {
    string      kw;
    string      val;
    bit         eq;
    int         len;
    bit         rs;
    bit         se;
    bit         typed;
    logic [2:0] kind;
    bit         dn;
    logic [2:0] st;
  } card_row_t;

  card_row_t directed_cards [] = '{
    '{"SIMPLE", "T", 1, 80, 1, 0, 1, fhcp_pkg::KIND_SIMPLE, 0, fhcp_pkg::ST_RUN},
    '{"BITPIX", "-64", 1, 80, 0, 0, 0, fhcp_pkg::KIND_FAIL, 0, fhcp_pkg::ST_RUN},
    '{"NAXIS", "1", 1, 80, 0, 0, 0, fhcp_pkg::KIND_FAIL, 0, fhcp_pkg::ST_RUN},
    '{"NAXIS1", "99999999999999", 1, 80, 0, 0, 0, fhcp_pkg::KIND_FAIL, 0, fhcp_pkg::ST_RUN},
    '{"END", "", 0, 80, 0, 0, 1, fhcp_pkg::KIND_END, 1, fhcp_pkg::ST_OK},
    '{"SIMPLE", "F", 1, 80, 1, 0, 1, fhcp_pkg::KIND_FAIL, 1, fhcp_pkg::ST_NOTSIMP},
    '{"NAXIS", "1", 1, 30, 1, 1, 1, fhcp_pkg::KIND_FAIL, 1, fhcp_pkg::ST_BADVAL}
  };

  function automatic string random_value(int pick);
    case (pick)
      0: return $sformatf("%0d", $urandom_range(2000));
      1: return $sformatf("-%0d", $urandom);
      2: return $sformatf("+%0d", $urandom);
      3: return $sformatf("%0d%0d", $urandom, $urandom);
      default: return $sformatf("%0d", $urandom_range(3));
    endcase
  endfunction

  // mangle value columns and the comment area so odd bytes reach the parser
  task automatic roughen(ref card_bytes_t c);
    int p;
    if ($urandom_range(3) == 0) begin
      p = $urandom_range(9, 20);
      c[p] = $urandom_range(1) ? 8'd0 : 8'd9;
    end
    if ($urandom_range(4) == 0) c[$urandom_range(9, 29)] = 8'($urandom_range(255));
    for (int i = 31; i < CardLen; i++)
      if ($urandom_range(7) == 0) c[i] = 8'($urandom_range(255));
  endtask

  // one random card, often after a restart, sometimes cut short by the stream end
  task automatic send_random_card(output int nbytes);
    card_bytes_t c;
    int len;
    bit rs, se;
    string kws [] = '{"SIMPLE", "BITPIX", "NAXIS", "NAXIS1", "NAXIS2", "COMMENT", "END"};
    c = make_card(kws[$urandom_range(6)], random_value($urandom_range(4)),
                  $urandom_range(7) != 0);
    roughen(c);
    if ($urandom_range(3) == 0) c[29] = "T";
    len = $urandom_range(1) ? CardLen : $urandom_range(1, CardLen);
    rs = $urandom_range(3) != 0;
    se = len < CardLen || $urandom_range(3) == 0;
    send_card(c, len, rs, se);
    nbytes = len;
  endtask

  // result side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else begin
      if (hold_start) begin
        hold_left = 600; hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--; pop <= 1'b0;
      end else pop <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    fhcp_pkg::result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (card_results.size() == 0) begin
        $error("card result with nothing expected: kind %0d status %0d", card_kind, status);
        errors++;
      end else begin
        want = card_results.pop_front();
        if (card_kind !== want.card_kind) begin
          $error("card_kind: expected %0d, got %0d", want.card_kind, card_kind); errors++;
        end
        if (done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, done_res); errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status); errors++;
        end
        if (pixel_type !== want.pixel_type) begin
          $error("pixel_type: expected %0d, got %0d", want.pixel_type, pixel_type); errors++;
        end
        if (num_axes !== want.num_axes) begin
          $error("num_axes: expected %0d, got %0d", want.num_axes, num_axes); errors++;
        end
        if (width !== want.width) begin
          $error("width: expected %0d, got %0d", want.width, width); errors++;
        end
        if (height !== want.height) begin
          $error("height: expected %0d, got %0d", want.height, height); errors++;
        end
        if (depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, depth); errors++;
        end
        if (pad_bytes !== want.pad_bytes) begin
          $error("pad_bytes: expected %0d, got %0d", want.pad_bytes, pad_bytes); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    fhcp_pkg::result_t typed_r;
    int phase_bytes, nbytes;
    clear_header_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cards[i]) begin
      typed_r = '0;
      typed_r.card_kind = directed_cards[i].kind;
      typed_r.done_res = directed_cards[i].dn;
      typed_r.status = directed_cards[i].st;
      send_card(make_card(directed_cards[i].kw, directed_cards[i].val, directed_cards[i].eq),
                directed_cards[i].len, directed_cards[i].rs, directed_cards[i].se,
                directed_cards[i].typed, typed_r);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 26) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 26) : 0;
      if (ph == 0) begin
        // fill the result queue: each restart byte that also ends the stream gives a result
        hold_start = 1'b1;
        for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(255)), 1, 1);
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        send_random_card(nbytes);
        phase_bytes += nbytes;
      end
    end
    push <= 1'b0;

    while (card_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[fits_header_card_parser_core.f]
rtl/fhcp_pkg.sv
rtl/fhcp_front.sv
rtl/fhcp_back.sv
rtl/fhcp_queue.sv
rtl/fits_header_card_parser_core.sv
rtl/fhcp_checker.sv
tb/sv/tb_fits_header_card_parser_core.sv
